>>> rtl/gta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_pkg
// Shared types and constants of the grid trilinear attenuation unit.
// ----------------------------------------------------------------------------
package gta_pkg;

	localparam int GRID_SIDE  = 8;
	localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W     = $clog2(GRID_CELLS);
	localparam int COORD_W    = $clog2(GRID_SIDE);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] CFG_BOX_MIN_X        = 3'd0;
	localparam logic [2:0] CFG_BOX_MIN_Y        = 3'd1;
	localparam logic [2:0] CFG_BOX_MIN_Z        = 3'd2;
	localparam logic [2:0] CFG_CELLS_PER_UNIT_X = 3'd3;
	localparam logic [2:0] CFG_CELLS_PER_UNIT_Y = 3'd4;
	localparam logic [2:0] CFG_CELLS_PER_UNIT_Z = 3'd5;

	typedef struct packed {
		logic               opcode;
		logic [8:0]         entry_index;
		logic [15:0]        entry_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} gta_req_t;

	typedef struct packed {
		logic [15:0] attenuation_value;
		logic        inside_grid;
	} gta_rsp_t;

endpackage

>>> rtl/grid_trilinear_attenuation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_trilinear_attenuation_unit
// Cubic attenuation grid with a trilinear lookup of Q16.16 points.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless out_ready holds the seven-stage
// pipeline; each corner of the blend has its own grid copy, so the eight reads
// happen in the same cycle.
// Reset clears the pipeline valid bits and loads the configuration defaults.
// The grid contents are undefined until written; there is no clearing pass.
module grid_trilinear_attenuation_unit import gta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  gta_req_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output gta_rsp_t    out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Axis 0 is x, 1 is y, 2 is z.
	localparam logic [63:0] T_LIMIT = 64'(GRID_SIDE) << 32;
	localparam logic [31:0] LAST_I  = 32'(GRID_SIDE - 1);

	function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] f);
		logic [32:0] acc;
		acc = 33'(a) * (33'd65536 - 33'(f)) + 33'(b) * 33'(f) + 33'd32768;
		return acc[31:16];
	endfunction

	function automatic logic [ADDR_W-1:0] lin(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		return ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(GRID_SIDE)
			+ ADDR_W'(z) * ADDR_W'(GRID_SIDE * GRID_SIDE);
	endfunction

	// Configuration registers.
	logic signed [31:0] box_min_q [3];
	logic [31:0]        cpu_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_min_q[a] <= '0;
				cpu_q[a]     <= 32'd65536;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_MIN_X:        box_min_q[0] <= cfg_data;
				CFG_BOX_MIN_Y:        box_min_q[1] <= cfg_data;
				CFG_BOX_MIN_Z:        box_min_q[2] <= cfg_data;
				CFG_CELLS_PER_UNIT_X: cpu_q[0] <= cfg_data;
				CFG_CELLS_PER_UNIT_Y: cpu_q[1] <= cfg_data;
				CFG_CELLS_PER_UNIT_Z: cpu_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage takes a new request when it is empty or its content moves on,
	// so bubbles close up while a result waits at the output.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7 = !v_s7 || out_ready;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 1: offset from the box corner, exact in 33 bits.
	logic               op_s1;
	logic [8:0]         widx_s1;
	logic [15:0]        wval_s1;
	logic signed [32:0] d_s1 [3];
	logic signed [32:0] d_in [3];

	always_comb begin
		d_in[0] = 33'(in_data.point_x) - 33'(box_min_q[0]);
		d_in[1] = 33'(in_data.point_y) - 33'(box_min_q[1]);
		d_in[2] = 33'(in_data.point_z) - 33'(box_min_q[2]);
	end

	// Stage 2: scale into grid units, Q32.32.
	logic        op_s2;
	logic [8:0]  widx_s2;
	logic [15:0] wval_s2;
	logic [63:0] t_s2 [3];
	logic [2:0]  ok_s2;
	logic [63:0] t_in [3];
	logic [2:0]  ok_in;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			t_in[a]  = d_s1[a][32] ? 64'd0 : 64'(d_s1[a][31:0]) * 64'(cpu_q[a]);
			ok_in[a] = !(d_s1[a][32] && (cpu_q[a] != 32'd0));
		end
	end

	// Stage 3: range check, lower corner and weight per axis, corner addresses.
	logic              op_s3;
	logic              wen_s3;
	logic [ADDR_W-1:0] waddr_s3;
	logic [15:0]       wval_s3;
	logic [ADDR_W-1:0] addr_s3 [8];
	logic [15:0]       w_s3 [3];
	logic              in_s3;

	logic [COORD_W-1:0] lo_c [3];
	logic [COORD_W-1:0] hi_c [3];
	logic [15:0]        w_c [3];
	logic [2:0]         ok_c;
	logic [ADDR_W-1:0]  addr_c [8];

	always_comb begin
		logic [47:0] g;
		logic [31:0] i0;
		for (int a = 0; a < 3; a++) begin
			ok_c[a] = ok_s2[a] && (t_s2[a] <= T_LIMIT);
			g       = t_s2[a][63:16] - 48'd32768;
			i0      = g[47:16];
			if (t_s2[a] < 64'h8000_0000) begin
				lo_c[a] = '0;
				w_c[a]  = '0;
			end else if (i0 >= LAST_I) begin
				lo_c[a] = COORD_W'(LAST_I);
				w_c[a]  = '0;
			end else begin
				lo_c[a] = i0[COORD_W-1:0];
				w_c[a]  = g[15:0];
			end
			hi_c[a] = (32'(lo_c[a]) == LAST_I) ? lo_c[a] : lo_c[a] + COORD_W'(1);
		end
		for (int c = 0; c < 8; c++) begin
			addr_c[c] = lin(c[2] ? hi_c[0] : lo_c[0], c[1] ? hi_c[1] : lo_c[1],
				c[0] ? hi_c[2] : lo_c[2]);
		end
	end

	// Stage 4: grid read. Writes are applied here as well, in request order.
	logic [15:0] grid_q [8][GRID_CELLS];
	logic        op_s4;
	logic [15:0] rd_s4 [8];
	logic [15:0] w_s4 [3];
	logic        in_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int c = 0; c < 8; c++) begin
				if (wen_s3) begin
					grid_q[c][waddr_s3] <= wval_s3;
				end
				rd_s4[c] <= grid_q[c][addr_s3[c]];
			end
		end
	end

	// Stages 5 to 7: blends along z, then y, then x.
	logic [15:0] zl_s5 [4];
	logic [15:0] yw_s5, xw_s5, xw_s6;
	logic        in_s5, in_s6;
	logic [15:0] yl_s6 [2];
	gta_rsp_t    out_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4 && (op_s4 == OP_QUERY);
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			op_s1   <= in_data.opcode;
			widx_s1 <= in_data.entry_index;
			wval_s1 <= in_data.entry_value;
			d_s1    <= d_in;
		end
		if (rdy2 && v_s1) begin
			op_s2   <= op_s1;
			widx_s2 <= widx_s1;
			wval_s2 <= wval_s1;
			t_s2    <= t_in;
			ok_s2   <= ok_in;
		end
		if (rdy3 && v_s2) begin
			op_s3    <= op_s2;
			wen_s3   <= (op_s2 == OP_WRITE) && (32'(widx_s2) < 32'(GRID_CELLS));
			waddr_s3 <= ADDR_W'(widx_s2);
			wval_s3  <= wval_s2;
			addr_s3  <= addr_c;
			w_s3     <= w_c;
			in_s3    <= &ok_c;
		end
		if (rdy4 && v_s3) begin
			op_s4 <= op_s3;
			w_s4  <= w_s3;
			in_s4 <= in_s3;
		end
		if (rdy5 && v_s4) begin
			for (int k = 0; k < 4; k++) begin
				zl_s5[k] <= lerp16(rd_s4[2*k], rd_s4[2*k+1], w_s4[2]);
			end
			yw_s5 <= w_s4[1];
			xw_s5 <= w_s4[0];
			in_s5 <= in_s4;
		end
		if (rdy6 && v_s5) begin
			yl_s6[0] <= lerp16(zl_s5[0], zl_s5[1], yw_s5);
			yl_s6[1] <= lerp16(zl_s5[2], zl_s5[3], yw_s5);
			xw_s6    <= xw_s5;
			in_s6    <= in_s5;
		end
		if (rdy7 && v_s6) begin
			out_s7.attenuation_value <= in_s6 ? lerp16(yl_s6[0], yl_s6[1], xw_s6) : 16'd0;
			out_s7.inside_grid       <= in_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_data  = out_s7;

endmodule

>>> tb/sv/grid_trilinear_attenuation_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_trilinear_attenuation_unit_tb
// Self-checking bench for the trilinear attenuation lookup. Grid writes and
// point queries are pushed through the request channel, and each query's
// expected attenuation is computed on the spot by a bit-exact predictor and
// compared field by field with what the unit returns.
// ----------------------------------------------------------------------------
module grid_trilinear_attenuation_unit_tb;
	import gta_pkg::*;

	// Clock, reset and the ports of the unit.
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	gta_req_t    in_data;
	logic        out_valid;
	logic        out_ready;
	gta_rsp_t    out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// Requests waiting to be driven, and the attenuation answers still owed.
	gta_req_t pending_requests[$];
	gta_rsp_t owed_answers[$];

	// The predictor's own copy of the grid and of the box registers.
	logic [15:0] shadow_grid [GRID_CELLS];
	logic [31:0] shadow_box_min [3];
	logic [31:0] shadow_cells_per_unit [3];

	int  mismatch_count;
	int  cycle_count;
	bit  quiet_phase;

	localparam int CYCLE_LIMIT = 400000;

	grid_trilinear_attenuation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Maps one axis into grid units. Returns 0 when the point is outside,
	// otherwise the lower and upper corners and the Q0.16 blend weight.
	function automatic bit map_to_grid(input logic [31:0] p, input logic [31:0] bmin,
			input logic [31:0] cpu, output int lo, output int hi, output int w);
		longint d;
		longint unsigned t;
		longint g;
		int i0;
		d = longint'($signed(p)) - longint'($signed(bmin));
		lo = 0; hi = 0; w = 0;
		if (d < 0) begin
			// A zero scale collapses every point onto the first cell edge.
			if (cpu != 0) return 0;
			t = 0;
		end else begin
			t = longint'(d) * longint'({32'd0, cpu});
		end
		if (t > (64'(GRID_SIDE) << 32)) return 0;
		g = longint'(t >> 16) - 32768;
		if (g < 0) return 1;
		i0 = int'(g >>> 16);
		w  = int'(g & 16'hFFFF);
		if (i0 >= GRID_SIDE - 1) begin
			i0 = GRID_SIDE - 1;
			w  = 0;
		end
		lo = i0;
		hi = (i0 + 1 < GRID_SIDE) ? i0 + 1 : i0;
		return 1;
	endfunction

	function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
			input int f);
		longint unsigned acc;
		acc = longint'(a) * (65536 - f) + longint'(b) * f + 32768;
		return 16'(acc >> 16);
	endfunction

	function automatic logic [15:0] grid_at(input int x, input int y, input int z);
		return shadow_grid[x + y * GRID_SIDE + z * GRID_SIDE * GRID_SIDE];
	endfunction

	// Applies one accepted request to the shadow state and, for a query, records the answer.
	task automatic predict_attenuation(input gta_req_t r);
		int x0, x1, xd, y0, y1, yd, z0, z1, zd;
		bit ok;
		logic [15:0] i1, i2, j1, j2, w1, w2;
		gta_rsp_t rsp;
		if (r.opcode == OP_WRITE) begin
			if (r.entry_index < GRID_CELLS) shadow_grid[r.entry_index] = r.entry_value;
			return;
		end
		ok = map_to_grid(r.point_x, shadow_box_min[0], shadow_cells_per_unit[0], x0, x1, xd);
		ok = map_to_grid(r.point_y, shadow_box_min[1], shadow_cells_per_unit[1], y0, y1, yd)
			&& ok;
		ok = map_to_grid(r.point_z, shadow_box_min[2], shadow_cells_per_unit[2], z0, z1, zd)
			&& ok;
		if (!ok) begin
			rsp = '0;
		end else begin
			// The blend runs along z, then y, then x.
			i1 = blend(grid_at(x0, y0, z0), grid_at(x0, y0, z1), zd);
			i2 = blend(grid_at(x0, y1, z0), grid_at(x0, y1, z1), zd);
			j1 = blend(grid_at(x1, y0, z0), grid_at(x1, y0, z1), zd);
			j2 = blend(grid_at(x1, y1, z0), grid_at(x1, y1, z1), zd);
			w1 = blend(i1, i2, yd);
			w2 = blend(j1, j2, yd);
			rsp.attenuation_value = blend(w1, w2, xd);
			rsp.inside_grid = 1'b1;
		end
		owed_answers.push_back(rsp);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Request driver: valid stays up with a stable payload until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) predict_attenuation(in_data);
			if (!in_valid || in_ready) begin
				if (pending_requests.size() > 0 &&
						(quiet_phase || $urandom_range(99) >= 14)) begin
					in_valid <= 1'b1;
					in_data  <= pending_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Answer monitor with a randomly stalling ready.
	always @(posedge clk or negedge arst_n) begin
		gta_rsp_t exp_rsp;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_answers.size() == 0) begin
					report_mismatch("answer with nothing owed");
				end else begin
					exp_rsp = owed_answers.pop_front();
					if (out_data.attenuation_value !== exp_rsp.attenuation_value)
						report_mismatch($sformatf("attenuation %h, wanted %h",
							out_data.attenuation_value, exp_rsp.attenuation_value));
					if (out_data.inside_grid !== exp_rsp.inside_grid)
						report_mismatch($sformatf("inside flag %b, wanted %b",
							out_data.inside_grid, exp_rsp.inside_grid));
				end
			end
			out_ready <= quiet_phase || ($urandom_range(99) >= 14);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Writes one register on the unit and in the shadow copy.
	task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx <= CFG_BOX_MIN_Z) shadow_box_min[idx] = val;
		else shadow_cells_per_unit[idx - CFG_CELLS_PER_UNIT_X] = val;
	endtask

	// Waits until every request went in and every answer came back, then
	// lets the pipeline drain.
	task automatic wait_idle();
		while (pending_requests.size() > 0 || in_valid || owed_answers.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic gta_req_t make_write(input int idx, input logic [15:0] val);
		gta_req_t r;
		r = '0;
		r.opcode      = OP_WRITE;
		r.entry_index = 9'(idx);
		r.entry_value = val;
		r.point_x = $urandom; r.point_y = $urandom; r.point_z = $urandom;
		return r;
	endfunction

	function automatic gta_req_t make_query(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz);
		gta_req_t r;
		r.opcode      = OP_QUERY;
		r.entry_index = 9'($urandom);
		r.entry_value = 16'($urandom);
		r.point_x = px; r.point_y = py; r.point_z = pz;
		return r;
	endfunction

	// A point somewhere in or near the box on one axis, for a unit scale box.
	function automatic logic [31:0] near_point(input logic [31:0] bmin);
		int unsigned k;
		k = $urandom_range(99);
		if (k < 80) return bmin + $urandom_range(GRID_SIDE * 65536);
		if (k < 90) return bmin - $urandom_range(70000);
		return $urandom;
	endfunction

	task automatic random_queries(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 10)
				pending_requests.push_back(make_write($urandom_range(GRID_CELLS - 1),
					16'($urandom)));
			else
				pending_requests.push_back(make_query(near_point(shadow_box_min[0]),
					near_point(shadow_box_min[1]), near_point(shadow_box_min[2])));
		end
	endtask

	initial begin
		mismatch_count = 0;
		cycle_count    = 0;
		quiet_phase    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_BOX_MIN_X;
		cfg_data  = '0;
		for (int i = 0; i < 3; i++) begin
			shadow_box_min[i] = 32'd0;
			shadow_cells_per_unit[i] = 32'd65536;
		end
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the whole grid first so that no query reads an unwritten entry.
		// The first entry and the last get the value extremes.
		for (int i = 0; i < GRID_CELLS; i++) begin
			if (i == 0) pending_requests.push_back(make_write(i, 16'h0000));
			else if (i == GRID_CELLS - 1) pending_requests.push_back(make_write(i, 16'hFFFF));
			else pending_requests.push_back(make_write(i, 16'($urandom)));
		end
		// An index that wraps at the field width, and a rewrite of the last entry.
		pending_requests.push_back(make_write(GRID_CELLS + 3, 16'h1234));
		pending_requests.push_back(make_write(511, 16'hABCD));

		// Directed queries with the reset box: below the first cell center,
		// exactly on the bounds, beyond the last center, and far outside.
		pending_requests.push_back(make_query(32'd0, 32'd0, 32'd0));
		pending_requests.push_back(make_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
		pending_requests.push_back(make_query(32'h0008_0000, 32'h0008_0000, 32'h0008_0000));
		pending_requests.push_back(make_query(32'h0008_0001, 32'h0001_0000, 32'h0001_0000));
		pending_requests.push_back(make_query(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000));
		pending_requests.push_back(make_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_4000));
		pending_requests.push_back(make_query(32'h0007_9000, 32'h0003_C000, 32'h0000_C000));
		pending_requests.push_back(make_query(32'h0003_7FFF, 32'h0007_FFFF, 32'h0004_8001));
		wait_idle();

		// Zero scale on x, offset box on the others.
		write_register(CFG_CELLS_PER_UNIT_X, 32'd0);
		write_register(CFG_BOX_MIN_Y, 32'hFFFE_0000);
		write_register(CFG_BOX_MIN_Z, 32'h0010_0000);
		pending_requests.push_back(make_query(32'h8000_0000, 32'hFFFE_0000, 32'h0010_0000));
		pending_requests.push_back(make_query(32'h7FFF_FFFF, 32'h0006_0000, 32'h0017_0000));
		random_queries(20);
		wait_idle();

		// Extremes of the box and scale registers.
		write_register(CFG_BOX_MIN_X, 32'h8000_0000);
		write_register(CFG_BOX_MIN_Y, 32'h7FFF_FFFF);
		write_register(CFG_CELLS_PER_UNIT_X, 32'hFFFF_FFFF);
		write_register(CFG_CELLS_PER_UNIT_Y, 32'h0000_0001);
		write_register(CFG_CELLS_PER_UNIT_Z, 32'h0002_0000);
		pending_requests.push_back(make_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000));
		pending_requests.push_back(make_query(32'h8000_0007, 32'h7FFF_FFFF, 32'h0013_0000));
		random_queries(20);
		wait_idle();

		// Ordinary scaled box, with a stretch of no idling at all.
		write_register(CFG_BOX_MIN_X, 32'hFFFF_0000);
		write_register(CFG_BOX_MIN_Y, 32'h0000_4000);
		write_register(CFG_BOX_MIN_Z, 32'hFFF0_0000);
		write_register(CFG_CELLS_PER_UNIT_X, 32'h0001_8000);
		write_register(CFG_CELLS_PER_UNIT_Y, 32'h0000_C000);
		write_register(CFG_CELLS_PER_UNIT_Z, 32'h0001_0000);
		quiet_phase = 1'b1;
		random_queries(25);
		wait_idle();
		quiet_phase = 1'b0;
		for (int k = 0; k < 8; k++)
			pending_requests.push_back(make_write($urandom_range(GRID_CELLS - 1), 16'($urandom)));
		random_queries(20);
		wait_idle();

		if (mismatch_count == 0 && owed_answers.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
